// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define PFB_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define PFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/pfb_pkg.sv -----
package pfb_pkg;

	localparam int COLUMNS_DEF = 128;
	localparam int PAGES_DEF   = 8;
	localparam int CLIP_DEF    = 128 - 2;

	typedef enum logic [1:0] {
		OP_PIXEL = 2'd0,
		OP_BLIT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACCESS,
		ST_FINISH
	} state_t;

endpackage

// ----- hw/rtl/page_framebuffer_blitter_core.sv -----
// Monochrome page framebuffer, PAGES pages of COLUMNS column bytes, bit 0 at
// the top row of a page.
// Request channel: in_valid/in_ready with operation and its fields; one
// request is worked at a time. Result channel: out_valid/out_ready with
// read_data, one result per request (the stored byte for a read, zero for
// every other operation).
// Pixel write, blit and read: the accept cycle reads the frame memory;
// the access state that follows sees its registered read data, writes
// the modified byte back and loads the result register.
// A blit spill byte is written during the accept cycle. Clear all sweeps
// the memory one byte a cycle, then delivers its result. After reset the
// same sweep over all PAGES*COLUMNS bytes (1024 by default) runs once
// with in_ready low and no result.
// The result register is separate from the work: a new request is taken
// while a result waits; if the receiver stalls, the next request holds in
// its final cycle until the result register frees up.
module page_framebuffer_blitter_core #(
	parameter int COLUMNS      = pfb_pkg::COLUMNS_DEF,
	parameter int PAGES        = pfb_pkg::PAGES_DEF,
	parameter int CLIP_COLUMNS = pfb_pkg::CLIP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic signed [7:0] column_origin,
	input  logic [5:0]        row,
	input  logic              pixel_on,
	input  logic [7:0]        image_byte,
	input  logic [6:0]        column_offset,
	input  logic [2:0]        page_offset,
	input  logic [2:0]        read_page,
	input  logic [6:0]        read_column,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_data
);

	localparam int DEPTH  = PAGES * COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	logic [7:0] mem [DEPTH];
	logic [7:0] mem_rd_q;

	pfb_pkg::state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              clr_resp_q;
	logic              out_valid_q;
	logic [7:0]        read_data_q;

	logic [ADDR_W-1:0] addr_s1;
	logic              wr_ok_s1;
	logic              rd_res_s1;
	logic [7:0]        and_s1;
	logic [7:0]        or_s1;

	pfb_pkg::op_t      op;
	logic              accept;
	logic              out_free;
	logic              is_pixel, is_blit;
	logic [8:0]        col_pix, col_blit, col;
	logic [3:0]        pg;
	logic              main_ok, spill_ok, rd_ok;
	logic [ADDR_W-1:0] main_addr, spill_addr, rd_addr;
	logic [15:0]       shifted;
	logic [7:0]        pix_mask, and_new, or_new;

	logic              mem_re, mem_we, push;
	logic [ADDR_W-1:0] mem_ra, mem_wa;
	logic [7:0]        mem_wd, push_data;

	assign op       = pfb_pkg::op_t'(operation);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign is_pixel = (op == pfb_pkg::OP_PIXEL);
	assign is_blit  = (op == pfb_pkg::OP_BLIT);

	// target column and page
	assign col_pix  = {column_origin[7], column_origin};
	assign col_blit = col_pix + {2'b00, column_offset};
	assign col      = is_blit ? col_blit : col_pix;
	assign pg       = is_blit ? ({1'b0, row[5:3]} + {1'b0, page_offset}) : {1'b0, row[5:3]};

	assign main_ok = (is_pixel || is_blit) && !col[8]
		&& (32'(col[7:0]) < 32'(CLIP_COLUMNS)) && (32'(col[7:0]) < 32'(COLUMNS))
		&& (32'(pg) < 32'(PAGES));
	assign spill_ok = is_blit && main_ok && (row[2:0] != 3'd0)
		&& (32'(pg) + 32'd1 < 32'(PAGES));
	assign rd_ok = (op == pfb_pkg::OP_READ)
		&& (32'(read_page) < 32'(PAGES)) && (32'(read_column) < 32'(COLUMNS));

	assign main_addr  = ADDR_W'(32'(pg) * 32'(COLUMNS) + 32'(col[7:0]));
	assign spill_addr = ADDR_W'(32'(main_addr) + 32'(COLUMNS));
	assign rd_addr    = ADDR_W'(32'(read_page) * 32'(COLUMNS) + 32'(read_column));

	assign shifted  = {8'h00, image_byte} << row[2:0];
	assign pix_mask = 8'h01 << row[2:0];
	assign and_new  = (is_pixel && !pixel_on) ? ~pix_mask : 8'hFF;
	assign or_new   = (is_pixel && pixel_on) ? pix_mask : (is_blit ? shifted[7:0] : 8'h00);

	assign mem_re = accept && (main_ok || rd_ok);
	assign mem_ra = rd_ok ? rd_addr : main_addr;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfb_pkg::ST_CLEAR: begin
				if (clr_cnt_q == LAST) begin
					state_d = clr_resp_q ? pfb_pkg::ST_FINISH : pfb_pkg::ST_IDLE;
				end
			end
			pfb_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (op == pfb_pkg::OP_CLEAR) ? pfb_pkg::ST_CLEAR : pfb_pkg::ST_ACCESS;
				end
			end
			pfb_pkg::ST_ACCESS, pfb_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = pfb_pkg::ST_IDLE;
				end
			end
			default: state_d = pfb_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = spill_addr;
		mem_wd    = shifted[15:8];
		push      = 1'b0;
		push_data = 8'h00;
		case (state_q)
			pfb_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = 8'h00;
			end
			pfb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				mem_we   = accept && spill_ok;
			end
			pfb_pkg::ST_ACCESS: begin
				push      = out_free;
				push_data = rd_res_s1 ? mem_rd_q : 8'h00;
				mem_we    = out_free && wr_ok_s1;
				mem_wa    = addr_s1;
				mem_wd    = (mem_rd_q & and_s1) | or_s1;
			end
			pfb_pkg::ST_FINISH: begin
				push = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfb_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			clr_resp_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pfb_pkg::ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end else if (accept && op == pfb_pkg::OP_CLEAR) begin
				clr_cnt_q  <= '0;
				clr_resp_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			read_data_q <= push_data;
		end
		if (accept) begin
			addr_s1   <= main_addr;
			wr_ok_s1  <= main_ok;
			rd_res_s1 <= rd_ok;
			and_s1    <= and_new;
			or_s1     <= or_new;
		end
	end

	// frame memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

endmodule

// ----- hw/rtl/pfb_checker.sv -----
`include "assert_macros.svh"

module pfb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [1:0]        operation,
	input logic              out_valid,
	input logic              out_ready,
	input logic [7:0]        read_data
);

	logic in_acc;
	logic short_op;

	assign in_acc   = in_valid && in_ready;
	assign short_op = (operation != pfb_pkg::OP_CLEAR);

	`PFB_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(read_data), "result dropped or changed while stalled")
	`PFB_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid && !in_ready, "channels active during reset")
	`PFB_ASSERT(a_one_at_a_time, clk, arst_n, in_acc |=> !in_ready, "request taken while another is in work")
	`PFB_ASSERT(a_short_latency, clk, arst_n, in_acc && short_op ##1 (!out_valid || out_ready) |=> out_valid, "no result two cycles after a short request")

endmodule

bind page_framebuffer_blitter_core pfb_checker u_pfb_checker (.*);
